@@ rtl/rabin_pkg.sv @@
// Shared constants, types and helper functions for the Rabin encrypt/decrypt block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package rabin_pkg;

    localparam int PRIME_BITS    = 16;
    localparam int MOD_BITS      = 2 * PRIME_BITS;
    localparam int VALUE_BITS    = 32;
    localparam int RESULT_BITS   = 32;
    localparam int DIV_BITS      = (MOD_BITS > VALUE_BITS) ? MOD_BITS : VALUE_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic [PRIME_BITS-1:0] prime_t;
    typedef logic [MOD_BITS-1:0]   mod_t;
    typedef logic [DIV_BITS-1:0]   div_t;

    localparam prime_t PRIME_P_RESET = prime_t'(23);
    localparam prime_t PRIME_Q_RESET = prime_t'(7);

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_PRIME_P = 1'b0,
        REG_PRIME_Q = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ENC_DIV,
        ST_ENC_MUL,
        ST_POW_START,
        ST_POW_LOOP,
        ST_POW_MULA,
        ST_POW_MULB,
        ST_INV_START,
        ST_INV_LOOP,
        ST_INV_DIV,
        ST_INV_MUL,
        ST_W_MUL,
        ST_X1_MUL,
        ST_X2_MUL,
        ST_ROOT
    } state_t;

    typedef struct packed {
        logic start;
        mod_t a;
        mod_t b;
        mod_t m;
    } mul_req_t;

    typedef struct packed {
        logic start;
        div_t dividend;
        div_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        div_t quotient;
        div_t remainder;
    } div_rsp_t;

    // Modular sum of two operands that are both already below m.
    function automatic mod_t add_mod(input mod_t x, input mod_t y, input mod_t m);
        logic [MOD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

    // Square root exponent (m+1)/4 for a prime that is 3 mod 4.
    function automatic prime_t root_exp(input prime_t m);
        logic [PRIME_BITS:0] s;
        s = {1'b0, m} + {{PRIME_BITS{1'b0}}, 1'b1};
        return s[PRIME_BITS:2];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rabin_encrypt_decrypt.sv @@
// Top level of the Rabin encrypt/decrypt unit: sequencer, APB registers and
// the shared serial divider and modular multiplier. Depends on rabin_pkg,
// rabin_regs, rabin_div and rabin_mulmod.
//
// Usage. An input beat on the s_ channel carries an opcode and a 32-bit value.
// Encrypt returns one result beat holding (value mod n)^2 mod n with n = p*q,
// root_index 0 and last set. Decrypt returns four result beats, the candidate
// roots built from the sign choices (v1,v2), (v1,-v2), (-v1,v2), (-v1,-v2),
// with root_index 0 to 3 and last set on the fourth.
// The block works on one item at a time: s_ready is high only while it is
// idle, and it drops from the accepted beat until the last result beat is taken.
// Every modular product runs through one shift-and-add multiplier that takes
// one multiplier bit per cycle, and every reduction and Euclid quotient through
// one restoring divider. A decrypt needs two exponentiations, each step a
// squaring plus a multiply on a set exponent bit, two extended Euclid runs
// and ten products modulo n. When the receiver stalls a result beat, the result
// register holds it and the sequencer waits. Reset (aresetn low at a clock
// edge) returns the sequencer to idle, drops m_valid and loads the prime
// registers with 23 and 7. A prime register holding zero acts as one.
`default_nettype none

module rabin_encrypt_decrypt (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [rabin_pkg::VALUE_BITS-1:0]    s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [rabin_pkg::RESULT_BITS-1:0]   m_result,
    output logic      [1:0]                          m_root_index,
    output logic                                     m_last,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rabin_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [rabin_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [rabin_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                     pready
);
    import rabin_pkg::*;

    prime_t   cfg_p, cfg_q;
    mul_req_t mul_req;
    logic     mul_done;
    mod_t     mul_prod;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rabin_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .prime_p (cfg_p),
        .prime_q (cfg_q)
    );

    rabin_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rabin_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Sequencer state and working registers.
    state_t                 state_reg, state_next;
    logic                   launched_reg, launched_next;
    opcode_t                op_reg, op_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    prime_t                 p_reg, p_next;
    prime_t                 q_reg, q_next;
    mod_t                   n_reg, n_next;
    logic                   pass_reg, pass_next;
    prime_t                 e_reg, e_next;
    prime_t                 base_reg, base_next;
    prime_t                 acc_reg, acc_next;
    prime_t                 v1_reg, v1_next;
    prime_t                 v2_reg, v2_next;
    prime_t                 ra_reg, ra_next;
    prime_t                 rb_reg, rb_next;
    prime_t                 ta_reg, ta_next;
    prime_t                 tb_reg, tb_next;
    prime_t                 quo_reg, quo_next;
    prime_t                 rn_reg, rn_next;
    prime_t                 inv1_reg, inv1_next;
    prime_t                 inv2_reg, inv2_next;
    mod_t                   w1_reg, w1_next;
    mod_t                   w2_reg, w2_next;
    mod_t                   x1_reg, x1_next;
    mod_t                   x2_reg, x2_next;
    logic [1:0]             k_reg, k_next;
    logic                   mvalid_reg, mvalid_next;
    logic [RESULT_BITS-1:0] res_reg, res_next;
    logic [1:0]             ridx_reg, ridx_next;
    logic                   last_reg, last_next;

    // Combinational helpers.
    prime_t              cur_m, oth_m;
    prime_t              n1, n2;
    prime_t              ta_red, tb_red, quo_red;
    prime_t              mul_low;
    logic [PRIME_BITS:0] tn_sum;
    prime_t              tn;
    mod_t                pq;
    mod_t                root;

    // The pass bit selects which prime the exponentiation or Euclid run is on.
    assign cur_m   = pass_reg ? q_reg : p_reg;
    assign oth_m   = pass_reg ? p_reg : q_reg;
    // Negation modulo the prime keeps a zero root at zero.
    assign n1      = (v1_reg == '0) ? '0 : p_reg - v1_reg;
    assign n2      = (v2_reg == '0) ? '0 : q_reg - v2_reg;
    assign ta_red  = (ta_reg >= cur_m) ? ta_reg - cur_m : ta_reg;
    assign tb_red  = (tb_reg >= cur_m) ? tb_reg - cur_m : tb_reg;
    assign quo_red = (quo_reg >= cur_m) ? quo_reg - cur_m : quo_reg;
    assign mul_low = mul_prod[PRIME_BITS-1:0];
    assign tn_sum  = {1'b0, ta_red} + {1'b0, cur_m - mul_low};
    assign tn      = (tn_sum >= {1'b0, cur_m}) ? PRIME_BITS'(tn_sum - {1'b0, cur_m})
                                               : tn_sum[PRIME_BITS-1:0];
    assign pq      = mod_t'(p_reg) * mod_t'(q_reg);
    assign root    = add_mod(x1_reg, x2_reg, n_reg);

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        pass_next     = pass_reg;
        e_next        = e_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        quo_next      = quo_reg;
        rn_next       = rn_reg;
        inv1_next     = inv1_reg;
        inv2_next     = inv2_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        x1_next       = x1_reg;
        x2_next       = x2_reg;
        k_next        = k_reg;
        mvalid_next   = mvalid_reg;
        res_next      = res_reg;
        ridx_next     = ridx_reg;
        last_next     = last_reg;
        mul_req       = '0;
        div_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = opcode_t'(s_opcode);
                    val_next   = s_value;
                    p_next     = (cfg_p == '0) ? prime_t'(1) : cfg_p;
                    q_next     = (cfg_q == '0) ? prime_t'(1) : cfg_q;
                    state_next = ST_PREP;
                end
            end

            ST_PREP: begin
                n_next    = pq;
                pass_next = 1'b0;
                if (op_reg == OP_ENCRYPT) begin
                    state_next = ST_ENC_DIV;
                end else begin
                    state_next = ST_POW_START;
                end
            end

            ST_ENC_DIV: begin
                div_req.dividend = div_t'(val_reg);
                div_req.divisor  = div_t'(n_reg);
                if (!launched_reg) begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_rsp.done) begin
                    launched_next = 1'b0;
                    x1_next       = div_rsp.remainder[MOD_BITS-1:0];
                    state_next    = ST_ENC_MUL;
                end
            end

            ST_ENC_MUL: begin
                mul_req.a = x1_reg;
                mul_req.b = x1_reg;
                mul_req.m = n_reg;
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    res_next      = RESULT_BITS'(mul_prod);
                    ridx_next     = 2'd0;
                    last_next     = 1'b1;
                    mvalid_next   = 1'b1;
                    state_next    = ST_ROOT;
                end
            end

            ST_POW_START: begin
                // Reduce the ciphertext modulo the current prime to seed the base.
                div_req.dividend = div_t'(val_reg);
                div_req.divisor  = div_t'(cur_m);
                if (!launched_reg) begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_rsp.done) begin
                    launched_next = 1'b0;
                    base_next     = div_rsp.remainder[PRIME_BITS-1:0];
                    acc_next      = prime_t'(1);
                    e_next        = root_exp(cur_m);
                    state_next    = ST_POW_LOOP;
                end
            end

            ST_POW_LOOP: begin
                if (e_reg == '0) begin
                    if (!pass_reg) begin
                        v1_next    = acc_reg;
                        pass_next  = 1'b1;
                        state_next = ST_POW_START;
                    end else begin
                        v2_next    = acc_reg;
                        pass_next  = 1'b0;
                        state_next = ST_INV_START;
                    end
                end else if (e_reg[0]) begin
                    state_next = ST_POW_MULA;
                end else begin
                    state_next = ST_POW_MULB;
                end
            end

            ST_POW_MULA: begin
                mul_req.a = mod_t'(acc_reg);
                mul_req.b = mod_t'(base_reg);
                mul_req.m = mod_t'(cur_m);
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    acc_next      = mul_low;
                    state_next    = ST_POW_MULB;
                end
            end

            ST_POW_MULB: begin
                mul_req.a = mod_t'(base_reg);
                mul_req.b = mod_t'(base_reg);
                mul_req.m = mod_t'(cur_m);
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    base_next     = mul_low;
                    e_next        = e_reg >> 1;
                    state_next    = ST_POW_LOOP;
                end
            end

            ST_INV_START: begin
                // Euclid on (m, other mod m); the coefficient is the CRT inverse.
                div_req.dividend = div_t'(oth_m);
                div_req.divisor  = div_t'(cur_m);
                if (!launched_reg) begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_rsp.done) begin
                    launched_next = 1'b0;
                    ra_next       = cur_m;
                    rb_next       = div_rsp.remainder[PRIME_BITS-1:0];
                    ta_next       = '0;
                    tb_next       = prime_t'(1);
                    state_next    = ST_INV_LOOP;
                end
            end

            ST_INV_LOOP: begin
                if (rb_reg == '0) begin
                    if (!pass_reg) begin
                        inv1_next  = ta_red;
                        pass_next  = 1'b1;
                        state_next = ST_INV_START;
                    end else begin
                        inv2_next  = ta_red;
                        pass_next  = 1'b0;
                        state_next = ST_W_MUL;
                    end
                end else begin
                    state_next = ST_INV_DIV;
                end
            end

            ST_INV_DIV: begin
                div_req.dividend = div_t'(ra_reg);
                div_req.divisor  = div_t'(rb_reg);
                if (!launched_reg) begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_rsp.done) begin
                    launched_next = 1'b0;
                    quo_next      = div_rsp.quotient[PRIME_BITS-1:0];
                    rn_next       = div_rsp.remainder[PRIME_BITS-1:0];
                    state_next    = ST_INV_MUL;
                end
            end

            ST_INV_MUL: begin
                mul_req.a = mod_t'(quo_red);
                mul_req.b = mod_t'(tb_red);
                mul_req.m = mod_t'(cur_m);
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    ra_next       = rb_reg;
                    rb_next       = rn_reg;
                    ta_next       = tb_reg;
                    tb_next       = tn;
                    state_next    = ST_INV_LOOP;
                end
            end

            ST_W_MUL: begin
                // Fold each inverse with the other prime once: w1 = inv1*q, w2 = inv2*p.
                mul_req.a = pass_reg ? mod_t'(inv2_reg) : mod_t'(inv1_reg);
                mul_req.b = pass_reg ? mod_t'(p_reg) : mod_t'(q_reg);
                mul_req.m = n_reg;
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    if (!pass_reg) begin
                        w1_next   = mul_prod;
                        pass_next = 1'b1;
                    end else begin
                        w2_next    = mul_prod;
                        pass_next  = 1'b0;
                        k_next     = 2'd0;
                        state_next = ST_X1_MUL;
                    end
                end
            end

            ST_X1_MUL: begin
                mul_req.a = k_reg[1] ? mod_t'(n1) : mod_t'(v1_reg);
                mul_req.b = w1_reg;
                mul_req.m = n_reg;
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    x1_next       = mul_prod;
                    state_next    = ST_X2_MUL;
                end
            end

            ST_X2_MUL: begin
                mul_req.a = k_reg[0] ? mod_t'(n2) : mod_t'(v2_reg);
                mul_req.b = w2_reg;
                mul_req.m = n_reg;
                if (!launched_reg) begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    x2_next       = mul_prod;
                    state_next    = ST_ROOT;
                end
            end

            ST_ROOT: begin
                // Load the result register on entry from decrypt, then hold
                // until the beat is taken.
                if (!mvalid_reg) begin
                    res_next    = RESULT_BITS'(root);
                    ridx_next   = k_reg;
                    last_next   = (k_reg == 2'd3);
                    mvalid_next = 1'b1;
                end else if (m_ready) begin
                    mvalid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_X1_MUL;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
            mvalid_reg   <= 1'b0;
            pass_reg     <= 1'b0;
            k_reg        <= 2'd0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            mvalid_reg   <= mvalid_next;
            pass_reg     <= pass_next;
            k_reg        <= k_next;
        end
        op_reg   <= op_next;
        val_reg  <= val_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        e_reg    <= e_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        quo_reg  <= quo_next;
        rn_reg   <= rn_next;
        inv1_reg <= inv1_next;
        inv2_reg <= inv2_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        res_reg  <= res_next;
        ridx_reg <= ridx_next;
        last_reg <= last_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = mvalid_reg;
    assign m_result     = res_reg;
    assign m_root_index = ridx_reg;
    assign m_last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/rabin_regs.sv @@
// APB register file holding the two secret primes.
// Depends on rabin_pkg.
`default_nettype none

module rabin_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rabin_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [rabin_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [rabin_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                     pready,
    output rabin_pkg::prime_t                        prime_p,
    output rabin_pkg::prime_t                        prime_q
);
    import rabin_pkg::*;

    prime_t     prime_p_reg;
    prime_t     prime_q_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_p_reg <= PRIME_P_RESET;
            prime_q_reg <= PRIME_Q_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_PRIME_P: prime_p_reg <= pwdata[PRIME_BITS-1:0];
                REG_PRIME_Q: prime_q_reg <= pwdata[PRIME_BITS-1:0];
                default:     prime_p_reg <= prime_p_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PRIME_P: prdata = APB_DATA_BITS'(prime_p_reg);
            REG_PRIME_Q: prdata = APB_DATA_BITS'(prime_q_reg);
            default:     prdata = '0;
        endcase
    end

    assign prime_p = prime_p_reg;
    assign prime_q = prime_q_reg;

endmodule

`default_nettype wire

@@ rtl/rabin_div.sv @@
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on rabin_pkg.
`default_nettype none

module rabin_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  rabin_pkg::div_req_t req,
    output rabin_pkg::div_rsp_t rsp
);
    import rabin_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    div_t                    quo_reg, quo_next;
    div_t                    rem_reg, rem_next;
    div_t                    dvs_reg, dvs_next;
    logic [DIV_BITS:0]       trial;

    assign trial = {rem_reg, quo_reg[DIV_BITS-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                cnt_next  = DIV_CNT_BITS'(DIV_BITS - 1);
                quo_next  = req.dividend;
                rem_next  = '0;
                dvs_next  = req.divisor;
            end
        end else begin
            // The dividend shifts out of the top while quotient bits enter below.
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_BITS-1:0];
                quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/rabin_mulmod.sv @@
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
// Depends on rabin_pkg (add_mod).
`default_nettype none

module rabin_mulmod (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  rabin_pkg::mul_req_t req,
    output logic               done,
    output rabin_pkg::mod_t    product
);
    import rabin_pkg::*;

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    mod_t a_reg, a_next;
    mod_t b_reg, b_next;
    mod_t m_reg, m_next;
    mod_t acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (!busy_reg) begin
            if (req.start) begin
                // Operands arrive no larger than the modulus, so one subtract reduces them.
                busy_next = 1'b1;
                m_next    = req.m;
                a_next    = (req.a >= req.m) ? req.a - req.m : req.a;
                b_next    = (req.b >= req.m) ? req.b - req.m : req.b;
                acc_next  = '0;
            end
        end else if (b_reg == '0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end else begin
            if (b_reg[0]) begin
                acc_next = add_mod(acc_reg, a_reg, m_reg);
            end
            a_next = add_mod(a_reg, a_reg, m_reg);
            b_next = b_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

@@ rtl/rabin_checker.sv @@
// Port-level checker for the Rabin encrypt/decrypt unit, with its bind.
// Depends on rabin_pkg and binds to rabin_encrypt_decrypt.
`default_nettype none

module rabin_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [rabin_pkg::RESULT_BITS-1:0]   m_result,
    input wire logic [1:0]                          m_root_index,
    input wire logic                                m_last
);
    import rabin_pkg::*;

    // A result beat waiting on the receiver stays offered.
    a_mvalid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the beat was taken");

    // A stalled result beat keeps its payload.
    a_mdata_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result) && $stable(m_root_index)
                                && $stable(m_last))
        else $error("result payload changed while stalled");

    // The block never takes a new item while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // After a non-final result beat the block keeps working on the same item.
    a_stay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("input ready before the final result beat");

    // Only the fourth decrypt root can carry index three, and it is final.
    a_last_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_index == 2'd3) |-> m_last)
        else $error("root index three without last");

endmodule

bind rabin_encrypt_decrypt rabin_checker u_rabin_checker (.*);

`default_nettype wire

@@ verif/tb_rabin_encrypt_decrypt.sv @@
// Self-checking testbench for the Rabin encrypt/decrypt unit.
// Depends on rabin_pkg and the rabin_encrypt_decrypt RTL; needs no files.

module tb_rabin_encrypt_decrypt;
    import rabin_pkg::*;

    // Cycle limit with no accepted beat. It must cover a whole decrypt and a
    // stalled result beat on top.
    localparam int STALL_LIMIT = 40000;
    // Idle cycles let pass before a register write, so the sequencer is surely done.
    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        opcode_t     op;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic [31:0] result;
        logic [1:0]  root_index;
        logic        last;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result;
    logic [1:0]  m_root_index;
    logic        m_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rabin_encrypt_decrypt dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .m_root_index(m_root_index), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model copy of the prime registers, kept in step with every write.
    logic [63:0] model_p = 64'd23;
    logic [63:0] model_q = 64'd7;

    request_t pending_requests[$];
    answer_t  expected_roots[$];
    int       error_count = 0;
    int       quiet_cycles = 0;
    bit       sender_idle_enable = 1'b1;
    bit       receiver_idle_enable = 1'b1;
    bit       sender_hold = 1'b0;

    // Exact modular product by shift and add; both operands fit easily in 64 bits.
    function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        a = a % m;
        b = b % m;
        while (b != 0) begin
            if (b[0]) acc = (acc + a) % m;
            a = (a + a) % m;
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] ex,
                                              logic [63:0] m);
        logic [63:0] acc;
        if (ex == 0) return 64'd1;
        acc = 1 % m;
        base = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = mod_product(acc, base, m);
            base = mod_product(base, base, m);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Euclid coefficient of a modulo m; for non-coprime primes the last
    // coefficient before the remainder hits zero is used as it stands.
    function automatic logic [63:0] euclid_inverse(logic [63:0] a, logic [63:0] m);
        logic [63:0] ra, rb, ta, tb, quo, rn, tn;
        ra = m;
        rb = a % m;
        ta = 0;
        tb = 1;
        while (rb > 0) begin
            quo = ra / rb;
            rn = ra % rb;
            tn = (ta % m + m - mod_product(quo, tb, m)) % m;
            ra = rb;
            rb = rn;
            ta = tb;
            tb = tn;
        end
        return ta % m;
    endfunction

    function automatic logic [63:0] crt_combine(logic [63:0] a1, logic [63:0] a2,
                                                logic [63:0] m1, logic [63:0] m2);
        logic [63:0] n, x1, x2;
        n = m1 * m2;
        x1 = mod_product(mod_product(a1, euclid_inverse(m2, m1), n), m2, n);
        x2 = mod_product(mod_product(a2, euclid_inverse(m1, m2), n), m1, n);
        return (x1 + x2) % n;
    endfunction

    // Push the result beats one request should produce.
    task automatic predict_rabin(request_t req);
        logic [63:0] p, q, n, v1, v2, n1, n2;
        logic [63:0] roots[4];
        answer_t a;
        p = (model_p == 0) ? 64'd1 : model_p;
        q = (model_q == 0) ? 64'd1 : model_q;
        n = p * q;
        if (req.op == OP_ENCRYPT) begin
            a.result = 32'(mod_product(req.value % n, req.value % n, n));
            a.root_index = 2'd0;
            a.last = 1'b1;
            expected_roots.push_back(a);
        end else begin
            v1 = mod_power(req.value, (p + 1) / 4, p);
            v2 = mod_power(req.value, (q + 1) / 4, q);
            n1 = (p - v1) % p;
            n2 = (q - v2) % q;
            roots[0] = crt_combine(v1, v2, p, q);
            roots[1] = crt_combine(v1, n2, p, q);
            roots[2] = crt_combine(n1, v2, p, q);
            roots[3] = crt_combine(n1, n2, p, q);
            for (int k = 0; k < 4; k++) begin
                a.result = 32'(roots[k]);
                a.root_index = 2'(k);
                a.last = (k == 3);
                expected_roots.push_back(a);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    // Driver: holds a beat steady until it is accepted, then loads the next one; it also drives m_ready.
    always @(posedge aclk) begin
        request_t next_req;
        if (aresetn) begin
            if (!(s_valid && !s_ready)) begin
                if (!sender_hold && pending_requests.size() > 0 &&
                    !(sender_idle_enable && $urandom_range(99) < 32)) begin
                    next_req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= next_req.op;
                    s_value <= next_req.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !(receiver_idle_enable && $urandom_range(99) < 32);
        end
    end

    // Monitor: predicts on every accepted input beat and checks every result
    // beat against the oldest expectation. It also runs the watchdog.
    always @(posedge aclk) begin
        request_t seen;
        answer_t want;
        bit any_beat;
        if (aresetn) begin
            any_beat = 1'b0;
            if (s_valid && s_ready) begin
                seen.op = opcode_t'(s_opcode);
                seen.value = s_value;
                predict_rabin(seen);
                any_beat = 1'b1;
            end
            if (m_valid && m_ready) begin
                any_beat = 1'b1;
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected beat", m_result, 32'd0);
                end else begin
                    want = expected_roots.pop_front();
                    if (m_result !== want.result)
                        report_mismatch("result", m_result, want.result);
                    if (m_root_index !== want.root_index)
                        report_mismatch("root_index", 32'(m_root_index), 32'(want.root_index));
                    if (m_last !== want.last)
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                end
            end
            quiet_cycles <= any_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Waits until every queued item has gone out and every result has come
    // back, then lets the block settle.
    task automatic drain_block();
        while (pending_requests.size() > 0 || s_valid || expected_roots.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB write: setup cycle then access cycle; pready is always high.
    task automatic write_prime(reg_index_t idx, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_ADDR_BITS'(4 * int'(idx));
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PRIME_P) model_p = {48'd0, data[15:0]};
        else model_q = {48'd0, data[15:0]};
    endtask

    task automatic queue_item(opcode_t op, logic [31:0] value);
        request_t r;
        r.op = op;
        r.value = value;
        pending_requests.push_back(r);
    endtask

    // Random values mostly small with respect to n, with full-width words mixed in.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_item($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
                       $urandom_range(3) == 0 ? $urandom : $urandom_range(4000));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset primes 23 and 7.
        queue_item(OP_ENCRYPT, 32'd0);
        queue_item(OP_ENCRYPT, 32'hFFFF_FFFF);
        queue_item(OP_ENCRYPT, 32'd160);
        queue_item(OP_DECRYPT, 32'd0);
        queue_item(OP_DECRYPT, 32'hFFFF_FFFF);
        queue_item(OP_DECRYPT, 32'd93);
        queue_item(OP_ENCRYPT, 32'h5555_5555);
        queue_item(OP_DECRYPT, 32'hAAAA_AAAA);
        drain_block();

        // Large 16-bit primes that are 3 mod 4; p is the largest such prime.
        write_prime(REG_PRIME_P, 32'd65519);
        write_prime(REG_PRIME_Q, 32'd65447);
        queue_item(OP_ENCRYPT, 32'hFFFF_FFFF);
        queue_item(OP_DECRYPT, 32'hFFFF_FFFF);
        queue_item(OP_DECRYPT, 32'h1234_5678);
        drain_block();

        // Zero prime acts as one, and a tiny prime yields a root of one.
        write_prime(REG_PRIME_P, 32'hFFFF_0000);
        write_prime(REG_PRIME_Q, 32'd2);
        queue_item(OP_ENCRYPT, 32'd77);
        queue_item(OP_DECRYPT, 32'd77);
        drain_block();

        // Non-coprime primes, then the prime 3 against the largest 16-bit value.
        write_prime(REG_PRIME_P, 32'd11);
        write_prime(REG_PRIME_Q, 32'd11);
        queue_item(OP_DECRYPT, 32'd5);
        queue_item(OP_ENCRYPT, 32'd500);
        drain_block();
        write_prime(REG_PRIME_P, 32'd3);
        write_prime(REG_PRIME_Q, 32'd65535);
        queue_item(OP_DECRYPT, 32'd4);
        queue_item(OP_ENCRYPT, 32'hDEAD_BEEF);
        drain_block();

        // Random part over several prime settings; the first one has no idling.
        write_prime(REG_PRIME_P, 32'd251);
        write_prime(REG_PRIME_Q, 32'd239);
        sender_idle_enable = 1'b0;
        receiver_idle_enable = 1'b0;
        queue_random(60);
        drain_block();
        sender_idle_enable = 1'b1;
        receiver_idle_enable = 1'b1;

        write_prime(REG_PRIME_P, 32'd1019);
        write_prime(REG_PRIME_Q, 32'd23);
        queue_random(100);
        // The sender holds off here until every result is back.
        while (pending_requests.size() > 0 || s_valid) @(posedge aclk);
        sender_hold = 1'b1;
        while (expected_roots.size() > 0) @(posedge aclk);
        sender_hold = 1'b0;
        queue_random(60);
        drain_block();

        write_prime(REG_PRIME_P, {16'hABCD, 16'd7});
        write_prime(REG_PRIME_Q, 32'd31);
        queue_random(80);
        drain_block();

        write_prime(REG_PRIME_P, 32'd65519);
        write_prime(REG_PRIME_Q, 32'd43);
        queue_random(60);
        drain_block();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
